>>> hw/rtl/rde_pkg.sv
// Shared package for the signed radix digit emitter.
// Holds widths, register indexes, character codes, handshake structs and symbol helpers.
// No dependencies.
package rde_pkg;

    // Sizes
    localparam int MAX_RADIX   = 16;
    localparam int SYM_W       = 8;
    localparam int SYM_COUNT   = 16;
    localparam int SYMS_W      = SYM_W * SYM_COUNT;
    localparam int SYM_IDX_W   = $clog2(SYM_COUNT);
    localparam int RADIX_W     = 5;
    localparam int VALUE_W     = 32;
    localparam int DIGIT_W     = 4;
    localparam int DIGIT_DEPTH = 32;
    localparam int STACK_W     = DIGIT_W * DIGIT_DEPTH;
    localparam int CNT_W       = $clog2(DIGIT_DEPTH + 1);
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 2;

    // Divider: quotient bits resolved per cycle and passes per digit
    localparam int DIV_STEPS   = 8;
    localparam int DIV_PASSES  = VALUE_W / DIV_STEPS;
    localparam int DIV_PASS_W  = $clog2(DIV_PASSES);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RADIX        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

    // Character codes
    localparam logic [SYM_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [SYM_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [SYM_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [SYM_W-1:0] CHAR_VT    = 8'h0B;
    localparam logic [SYM_W-1:0] CHAR_FF    = 8'h0C;
    localparam logic [SYM_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [SYM_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;

    // Alphabet check handshake
    typedef struct packed {
        logic start;
    } chk_req_t;

    typedef struct packed {
        logic done;
        logic ok;
    } chk_rsp_t;

    // Digit divider handshake
    typedef struct packed {
        logic               start;
        logic [VALUE_W-1:0] dividend;
        logic [RADIX_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [VALUE_W-1:0] quotient;
        logic [DIGIT_W-1:0] remainder;
    } div_rsp_t;

    // Symbol k of the packed alphabet
    function automatic logic [SYM_W-1:0] sym_at(input logic [SYMS_W-1:0] syms,
                                                input logic [SYM_IDX_W-1:0] idx);
        return syms[{idx, 3'b000} +: SYM_W];
    endfunction

    // Whitespace, sign characters and NUL cannot be digits
    function automatic logic sym_forbidden(input logic [SYM_W-1:0] c);
        return (c == CHAR_NUL) || (c == CHAR_SPACE) || (c == CHAR_LF) ||
               (c == CHAR_TAB) || (c == CHAR_VT) || (c == CHAR_FF) ||
               (c == CHAR_CR) || (c == CHAR_PLUS) || (c == CHAR_MINUS);
    endfunction

endpackage

>>> hw/rtl/rde_alpha_check.sv
// Alphabet validity checker: walks the used symbols one per cycle.
// Each cycle tests one symbol for forbidden codes and duplicates among later symbols.
// Depends on rde_pkg.
module rde_alpha_check
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  rde_pkg::chk_req_t             req,
    input  logic [rde_pkg::RADIX_W-1:0]   radix,
    input  logic [rde_pkg::SYMS_W-1:0]    symbols,
    output rde_pkg::chk_rsp_t             rsp
);

    logic                            busy_reg,  busy_next;
    logic                            done_reg,  done_next;
    logic                            ok_reg,    ok_next;
    logic [rde_pkg::SYM_IDX_W-1:0]   idx_reg,   idx_next;

    logic [rde_pkg::SYM_W-1:0]       cur_sym;
    logic                            dup;
    logic                            bad;
    logic                            last_idx;
    logic                            radix_ok;

    // Symbol under test and its duplicate search over later positions
    always_comb
    begin
        cur_sym = rde_pkg::sym_at(symbols, idx_reg);
        dup     = 1'b0;
        for (int j = 0; j < rde_pkg::SYM_COUNT; j++)
        begin
            if ((rde_pkg::SYM_IDX_W'(j) > idx_reg) &&
                (rde_pkg::RADIX_W'(j) < radix) &&
                (rde_pkg::sym_at(symbols, rde_pkg::SYM_IDX_W'(j)) == cur_sym))
            begin
                dup = 1'b1;
            end
        end
        bad      = dup || rde_pkg::sym_forbidden(cur_sym);
        last_idx = ({1'b0, idx_reg} == (radix - rde_pkg::RADIX_W'(1)));
        radix_ok = (radix >= rde_pkg::RADIX_W'(2)) &&
                   (radix <= rde_pkg::RADIX_W'(rde_pkg::MAX_RADIX));
    end

    // Sequencer
    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        ok_next   = ok_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            idx_next = '0;
            if (radix_ok)
            begin
                busy_next = 1'b1;
            end
            else
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                ok_next   = 1'b0;
            end
        end
        else if (busy_reg)
        begin
            if (bad || last_idx)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                ok_next   = !bad;
            end
            else
            begin
                idx_next = idx_reg + rde_pkg::SYM_IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        ok_reg  <= ok_next;
    end

    assign rsp.done = done_reg;
    assign rsp.ok   = ok_reg;

endmodule

>>> hw/rtl/rde_div_unit.sv
// Iterative divider by a small radix: restoring division, several quotient bits per cycle.
// Gives quotient and remainder (one digit) once the last pass is done.
// Depends on rde_pkg.
module rde_div_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  rde_pkg::div_req_t  req,
    output rde_pkg::div_rsp_t  rsp
);

    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic [rde_pkg::DIV_PASS_W-1:0]   pass_reg, pass_next;
    logic [rde_pkg::VALUE_W-1:0]      q_reg,    q_next;
    logic [rde_pkg::DIGIT_W-1:0]      r_reg,    r_next;
    logic [rde_pkg::RADIX_W-1:0]      dvs_reg,  dvs_next;

    logic [rde_pkg::VALUE_W-1:0]      q_step;
    logic [rde_pkg::DIGIT_W-1:0]      r_step;

    // One pass: DIV_STEPS restoring steps on the narrow remainder
    always_comb
    begin
        logic [rde_pkg::DIGIT_W:0] t;
        q_step = q_reg;
        r_step = r_reg;
        for (int k = 0; k < rde_pkg::DIV_STEPS; k++)
        begin
            t = {r_step, q_step[rde_pkg::VALUE_W-1]};
            q_step = {q_step[rde_pkg::VALUE_W-2:0], 1'b0};
            if (t >= dvs_reg)
            begin
                t = t - dvs_reg;
                q_step[0] = 1'b1;
            end
            r_step = t[rde_pkg::DIGIT_W-1:0];
        end
    end

    // Pass counter and operand registers
    always_comb
    begin
        busy_next = busy_reg;
        pass_next = pass_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        dvs_next  = dvs_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            busy_next = 1'b1;
            pass_next = '0;
            q_next    = req.dividend;
            r_next    = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            q_next    = q_step;
            r_next    = r_step;
            pass_next = pass_reg + rde_pkg::DIV_PASS_W'(1);
            if (pass_reg == rde_pkg::DIV_PASS_W'(rde_pkg::DIV_PASSES - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            pass_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            pass_reg <= pass_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = q_reg;
    assign rsp.remainder = r_reg;

endmodule

>>> hw/rtl/signed_radix_digit_emitter.sv
// Signed radix digit emitter, top level. Takes one signed 32-bit value per item and emits
// its text in the configured radix and alphabet, one character per output item, with last
// set on the final character; a negative value starts with '-'. An invalid alphabet (radix
// below 2 or above 16, a whitespace, '+', '-' or NUL symbol, or a repeated symbol among
// those in use) gives no output for the item. One item at a time: the alphabet is checked
// at one symbol per cycle, then each digit goes through the shared divider (a load, then
// four passes that each resolve eight quotient bits), and then the sign and the digit
// characters go out as the output takes them. in_ready is high whenever no item is in
// progress, even while the final character still waits on the output.
// Depends on rde_pkg, rde_alpha_check and rde_div_unit.
module signed_radix_digit_emitter
(
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write port
    input  logic                               cfg_we,
    input  logic [rde_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rde_pkg::CFG_DATA_W-1:0]     cfg_data,
    // input items
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [rde_pkg::VALUE_W-1:0] value,
    // output items
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [rde_pkg::SYM_W-1:0]          character,
    output logic                               last
);

    typedef enum logic [4:0]
    {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_DIV   = 5'b00100,
        S_SIGN  = 5'b01000,
        S_EMIT  = 5'b10000
    } state_t;

    // Configuration
    logic [rde_pkg::RADIX_W-1:0]      radix_reg;
    logic [rde_pkg::CFG_DATA_W-1:0]   sym_low_reg;
    logic [rde_pkg::CFG_DATA_W-1:0]   sym_high_reg;
    logic [rde_pkg::SYMS_W-1:0]       symbols;

    // Sequencer and item state
    state_t                           state_reg,   state_next;
    logic                             neg_reg,     neg_next;
    logic [rde_pkg::VALUE_W-1:0]      mag_reg,     mag_next;
    logic [rde_pkg::CNT_W-1:0]        cnt_reg,     cnt_next;
    logic [rde_pkg::STACK_W-1:0]      stack_reg,   stack_next;

    // Output register
    logic                             ovalid_reg,  ovalid_next;
    logic [rde_pkg::SYM_W-1:0]        char_reg,    char_next;
    logic                             last_reg,    last_next;

    rde_pkg::chk_req_t                chk_req;
    rde_pkg::chk_rsp_t                chk_rsp;
    rde_pkg::div_req_t                div_req;
    rde_pkg::div_rsp_t                div_rsp;

    logic                             out_free;
    logic [rde_pkg::VALUE_W-1:0]      value_u;

    assign symbols = {sym_high_reg, sym_low_reg};
    assign value_u = value;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg    <= '0;
            sym_low_reg  <= '0;
            sym_high_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rde_pkg::REG_RADIX:        radix_reg    <= cfg_data[rde_pkg::RADIX_W-1:0];
                rde_pkg::REG_SYMBOLS_LOW:  sym_low_reg  <= cfg_data;
                rde_pkg::REG_SYMBOLS_HIGH: sym_high_reg <= cfg_data;
                default:                   ;
            endcase
        end
    end

    rde_alpha_check u_check
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (chk_req),
        .radix   (radix_reg),
        .symbols (symbols),
        .rsp     (chk_rsp)
    );

    rde_div_unit u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign out_free = !ovalid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);

    // Sequencer: check, divide digits into the stack, then emit sign and digits
    always_comb
    begin
        state_next       = state_reg;
        neg_next         = neg_reg;
        mag_next         = mag_reg;
        cnt_next         = cnt_reg;
        stack_next       = stack_reg;
        ovalid_next      = ovalid_reg;
        char_next        = char_reg;
        last_next        = last_reg;
        chk_req.start    = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = mag_reg;
        div_req.divisor  = radix_reg;

        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    neg_next      = value_u[rde_pkg::VALUE_W-1];
                    mag_next      = value_u[rde_pkg::VALUE_W-1] ?
                                    (rde_pkg::VALUE_W'(0) - value_u) : value_u;
                    cnt_next      = '0;
                    chk_req.start = 1'b1;
                    state_next    = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (chk_rsp.done)
                begin
                    if (chk_rsp.ok)
                    begin
                        div_req.start = 1'b1;
                        state_next    = S_DIV;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    // newest digit (most significant so far) sits at the bottom
                    stack_next = {stack_reg[rde_pkg::STACK_W-rde_pkg::DIGIT_W-1:0],
                                  div_rsp.remainder};
                    cnt_next   = cnt_reg + rde_pkg::CNT_W'(1);
                    mag_next   = div_rsp.quotient;
                    if ((div_rsp.quotient != '0) &&
                        (cnt_reg < rde_pkg::CNT_W'(rde_pkg::DIGIT_DEPTH - 1)))
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = div_rsp.quotient;
                    end
                    else
                    begin
                        state_next = neg_reg ? S_SIGN : S_EMIT;
                    end
                end
            end
            S_SIGN:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    char_next   = rde_pkg::CHAR_MINUS;
                    last_next   = 1'b0;
                    state_next  = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    char_next   = rde_pkg::sym_at(symbols, stack_reg[rde_pkg::DIGIT_W-1:0]);
                    last_next   = (cnt_reg == rde_pkg::CNT_W'(1));
                    stack_next  = stack_reg >> rde_pkg::DIGIT_W;
                    cnt_next    = cnt_reg - rde_pkg::CNT_W'(1);
                    if (cnt_reg == rde_pkg::CNT_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        neg_reg   <= neg_next;
        mag_reg   <= mag_next;
        stack_reg <= stack_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
    end

    assign out_valid = ovalid_reg;
    assign character = char_reg;
    assign last      = last_reg;

endmodule

>>> tb/signed_radix_digit_emitter_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for signed_radix_digit_emitter: directed and random values under
// a range of valid and broken alphabets, checked character by character.
// Depends on rde_pkg and the signed_radix_digit_emitter RTL.
module signed_radix_digit_emitter_tb;

    localparam int WATCHDOG_LIMIT = 4000;
    // Worst item: 16 symbol checks, 32 digit divisions, 33 characters
    localparam int SETTLE_CYCLES  = 300;
    localparam int RANDOM_ITEMS   = 185;
    localparam int MAX_REPORTS    = 50;

    typedef struct {
        logic [rde_pkg::SYM_W-1:0] ch;
        logic                      lst;
    } text_char_t;

    logic                               clk       = 1'b0;
    logic                               rst_n     = 1'b0;
    logic                               cfg_we    = 1'b0;
    logic [rde_pkg::CFG_IDX_W-1:0]      cfg_index = rde_pkg::REG_RADIX;
    logic [rde_pkg::CFG_DATA_W-1:0]     cfg_data  = '0;
    logic                               in_valid  = 1'b0;
    logic                               in_ready;
    logic signed [rde_pkg::VALUE_W-1:0] value     = '0;
    logic                               out_valid;
    logic                               out_ready = 1'b0;
    logic [rde_pkg::SYM_W-1:0]          character;
    logic                               last;

    // Shadow copy of the alphabet registers
    logic [rde_pkg::RADIX_W-1:0]        base_shadow = '0;
    logic [rde_pkg::SYMS_W-1:0]         syms_shadow = '0;

    logic signed [rde_pkg::VALUE_W-1:0] pending_values[$];
    text_char_t                         expected_text[$];
    int                                 values_pushed   = 0;
    int                                 values_accepted = 0;
    int                                 fail_count      = 0;
    int                                 quiet_cycles    = 0;
    int                                 send_idle_pct   = 30;
    int                                 ready_stall_pct = 67;

    logic [rde_pkg::SYM_W-1:0] bad_symbols[9] = '{rde_pkg::CHAR_NUL, rde_pkg::CHAR_SPACE,
                                                  rde_pkg::CHAR_LF, rde_pkg::CHAR_TAB,
                                                  rde_pkg::CHAR_VT, rde_pkg::CHAR_FF,
                                                  rde_pkg::CHAR_CR, rde_pkg::CHAR_PLUS,
                                                  rde_pkg::CHAR_MINUS};

    signed_radix_digit_emitter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .character (character),
        .last      (last)
    );

    always #10 clk = ~clk;

    function automatic bit is_reserved_char(input logic [rde_pkg::SYM_W-1:0] c);
        bit hit;
        hit = 1'b0;
        foreach (bad_symbols[k])
            if (c == bad_symbols[k])
                hit = 1'b1;
        return hit;
    endfunction

    // Alphabet in use must have a legal base, no reserved and no repeated symbols
    function automatic bit alphabet_ok();
        int n;
        n = int'(base_shadow);
        if (n < 2 || n > rde_pkg::MAX_RADIX)
            return 1'b0;
        for (int i = 0; i < n; i++)
        begin
            if (is_reserved_char(syms_shadow[8*i +: 8]))
                return 1'b0;
            for (int j = i + 1; j < n; j++)
                if (syms_shadow[8*i +: 8] == syms_shadow[8*j +: 8])
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    // Expected text of one value: optional minus, then digits most significant first
    function automatic void predict_text(input logic signed [rde_pkg::VALUE_W-1:0] v);
        logic [rde_pkg::VALUE_W-1:0] mag;
        int                          digit_vals[32];
        int                          nd;
        int                          base;
        text_char_t                  tc;
        nd = 0;
        if (!alphabet_ok())
            return;
        base = int'(base_shadow);
        mag  = v[rde_pkg::VALUE_W-1] ? (32'd0 - v) : v;
        do
        begin
            digit_vals[nd] = mag % base;
            mag = mag / base;
            nd++;
        end
        while (mag != 0 && nd < 32);
        if (v[rde_pkg::VALUE_W-1])
        begin
            tc.ch  = rde_pkg::CHAR_MINUS;
            tc.lst = 1'b0;
            expected_text.push_back(tc);
        end
        for (int k = nd - 1; k >= 0; k--)
        begin
            tc.ch  = syms_shadow[8*digit_vals[k] +: 8];
            tc.lst = (k == 0);
            expected_text.push_back(tc);
        end
    endfunction

    // Distinct legal symbols below n, anything at all above
    function automatic logic [rde_pkg::SYMS_W-1:0] random_alphabet(input int n);
        logic [rde_pkg::SYMS_W-1:0] s;
        logic [rde_pkg::SYM_W-1:0]  c;
        bit                         clash;
        s = '0;
        for (int k = 0; k < rde_pkg::SYM_COUNT; k++)
        begin
            if (k < n)
            begin
                do
                begin
                    c = rde_pkg::SYM_W'($urandom_range(0, 255));
                    clash = is_reserved_char(c);
                    for (int j = 0; j < k; j++)
                        if (s[8*j +: 8] == c)
                            clash = 1'b1;
                end
                while (clash);
            end
            else
                c = rde_pkg::SYM_W'($urandom_range(0, 255));
            s[8*k +: 8] = c;
        end
        return s;
    endfunction

    function automatic logic signed [rde_pkg::VALUE_W-1:0] random_value();
        logic [rde_pkg::VALUE_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom;
            4, 5:       v = $urandom_range(0, 300);
            6:          v = 32'd0 - $urandom_range(1, 300);
            7:
            begin
                case ($urandom_range(0, 4))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7FFF_FFFF;
                    2:       v = 32'hFFFF_FFFF;
                    3:       v = 32'h0000_0001;
                    default: v = 32'h0000_0000;
                endcase
            end
            default:
            begin
                v = $urandom >> $urandom_range(0, 31);
                if ($urandom_range(0, 1))
                    v = 32'd0 - v;
            end
        endcase
        return v;
    endfunction

    // Write all three alphabet registers, one per cycle; caller sits at a rising edge
    task automatic set_alphabet(input logic [rde_pkg::RADIX_W-1:0] n, input logic [63:0] lo,
                                input logic [63:0] hi);
        logic [rde_pkg::CFG_DATA_W-1:0] junk;
        junk      = {$urandom, $urandom};
        cfg_we    <= 1'b1;
        cfg_index <= rde_pkg::REG_RADIX;
        // bits above the radix field are don't-care for the block
        cfg_data  <= {junk[rde_pkg::CFG_DATA_W-1:rde_pkg::RADIX_W], n};
        @(posedge clk);
        cfg_index <= rde_pkg::REG_SYMBOLS_LOW;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= rde_pkg::REG_SYMBOLS_HIGH;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_we    <= 1'b0;
        base_shadow = n;
        syms_shadow = {hi, lo};
    endtask

    task automatic queue_value(input logic signed [rde_pkg::VALUE_W-1:0] v);
        pending_values.push_back(v);
        values_pushed++;
    endtask

    // Hold off until every item is taken and every character has come out
    task automatic settle(input int extra);
        while (values_accepted != values_pushed || expected_text.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    // Input driver
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_text(value);
                values_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_values.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    value    <= pending_values.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Output monitor, receiver stalls and watchdog
    always @(posedge clk)
    begin
        text_char_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_text.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $error("unexpected item: character 8'h%02h, last %0b", character, last);
                end
                else
                begin
                    want = expected_text.pop_front();
                    if (character !== want.ch)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $error("character: expected 8'h%02h, got 8'h%02h",
                                   want.ch, character);
                    end
                    if (last !== want.lst)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $error("last: expected %0b, got %0b", want.lst, last);
                    end
                end
            end
            out_ready <= ($urandom_range(0, 99) >= ready_stall_pct);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Stimulus sequence
    initial
    begin
        int                         n;
        int                         seg_items;
        int                         valid_done;
        int                         i;
        int                         j;
        bit                         broken;
        logic [rde_pkg::SYMS_W-1:0] syms;

        valid_done = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Registers still at reset: radix 0, nothing comes out
        queue_value(32'sd12345);
        settle(SETTLE_CYCLES);

        // Decimal, including both extremes; pause mid-way until the output drains
        set_alphabet(5'd10, "76543210", {48'd0, "98"});
        queue_value(32'sd0);
        queue_value(32'sd1);
        queue_value(-32'sd1);
        queue_value(32'h7FFF_FFFF);
        queue_value(32'h8000_0000);
        queue_value(32'sd10);
        settle(0);
        queue_value(-32'sd10);
        queue_value(32'sd90);
        settle(SETTLE_CYCLES);

        // Binary: most negative value gives the longest text
        set_alphabet(5'd2, {48'd0, "10"}, {$urandom, $urandom});
        queue_value(32'h8000_0000);
        queue_value(32'h7FFF_FFFF);
        queue_value(32'sd0);
        settle(SETTLE_CYCLES);

        // Full sixteen-symbol alphabet
        set_alphabet(5'd16, "76543210", "FEDCBA98");
        queue_value(32'h8000_0000);
        queue_value(-32'sd1);
        queue_value(32'h7FFF_FFFF);
        queue_value(32'sd255);
        settle(SETTLE_CYCLES);

        // Symbols with the top bit set
        set_alphabet(5'd16, 64'hF7F6_F5F4_F3F2_F1F0, 64'hFFFE_FDFC_FBFA_F9F8);
        queue_value(32'hFEDC_BA98);
        settle(SETTLE_CYCLES);

        // Base too small or too large: no output
        set_alphabet(5'd1, "76543210", "FEDCBA98");
        queue_value(32'sd7);
        settle(SETTLE_CYCLES);
        set_alphabet(5'd17, "76543210", "FEDCBA98");
        queue_value(32'sd7);
        settle(SETTLE_CYCLES);
        set_alphabet(5'd31, "76543210", "FEDCBA98");
        queue_value(-32'sd7);
        settle(SETTLE_CYCLES);

        // Minus sign used as a digit
        set_alphabet(5'd10, "76543210", {48'd0, rde_pkg::CHAR_MINUS, "8"});
        queue_value(32'sd99);
        settle(SETTLE_CYCLES);

        // Repeated symbol at the two ends of a full alphabet
        set_alphabet(5'd16, "76543210", "0EDCBA98");
        queue_value(32'sd99);
        settle(SETTLE_CYCLES);

        // Reserved and repeated symbols above the radix are ignored
        set_alphabet(5'd3, {rde_pkg::CHAR_MINUS, rde_pkg::CHAR_SPACE, rde_pkg::CHAR_NUL,
                            rde_pkg::CHAR_NUL, rde_pkg::CHAR_PLUS, "cba"}, '0);
        queue_value(-32'sd7);
        settle(SETTLE_CYCLES);

        // Random alphabets, each with a burst of random values
        while (valid_done < RANDOM_ITEMS)
        begin
            if (valid_done < 70)
            begin
                send_idle_pct   = 30;
                ready_stall_pct = 67;
            end
            else if (valid_done < 140)
            begin
                send_idle_pct   = 67;
                ready_stall_pct = 30;
            end
            else
            begin
                send_idle_pct   = 0;
                ready_stall_pct = 0;
            end

            case ($urandom_range(0, 5))
                0:       n = 2;
                1:       n = rde_pkg::MAX_RADIX;
                default: n = $urandom_range(2, rde_pkg::MAX_RADIX);
            endcase
            syms   = random_alphabet(n);
            broken = ($urandom_range(0, 99) < 20);
            if (broken)
            begin
                case ($urandom_range(0, 2))
                    0:
                    begin
                        if ($urandom_range(0, 1))
                            n = $urandom_range(0, 1);
                        else
                            n = $urandom_range(rde_pkg::MAX_RADIX + 1, 31);
                    end
                    1:
                    begin
                        i = $urandom_range(0, n - 1);
                        syms[8*i +: 8] = bad_symbols[$urandom_range(0, 8)];
                    end
                    default:
                    begin
                        i = $urandom_range(0, n - 1);
                        do
                            j = $urandom_range(0, n - 1);
                        while (j == i);
                        syms[8*j +: 8] = syms[8*i +: 8];
                    end
                endcase
            end
            set_alphabet(n[rde_pkg::RADIX_W-1:0], syms[63:0], syms[127:64]);

            seg_items = broken ? $urandom_range(2, 4) : $urandom_range(4, 12);
            for (int k = 0; k < seg_items; k++)
            begin
                queue_value(random_value());
                // now and then let the text drain in the middle of a burst
                if (k == seg_items / 2 && $urandom_range(0, 7) == 0)
                    settle(0);
            end
            if (!broken)
                valid_done += seg_items;
            settle(SETTLE_CYCLES);
        end

        settle(SETTLE_CYCLES);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> signed_radix_digit_emitter.f
hw/rtl/rde_pkg.sv
hw/rtl/rde_alpha_check.sv
hw/rtl/rde_div_unit.sv
hw/rtl/signed_radix_digit_emitter.sv
tb/signed_radix_digit_emitter_tb.sv
